// ===== sv/spq_pkg.sv =====
package spq_pkg;

    localparam int CAPACITY      = 16;
    localparam int TAG_BITS      = 32;
    localparam int PRIORITY_BITS = 8;
    localparam int OCC_BITS      = 5;
    localparam int COUNT_BITS    = $clog2(CAPACITY + 1);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef struct packed {
        logic load;
        logic insert;
        logic remove;
        logic respond;
    } cmd_t;

    typedef struct packed {
        logic op_remove;
        logic full;
        logic empty;
    } status_t;

endpackage

// ===== sv/spq_ctrl.sv =====
module spq_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  spq_pkg::status_t status,
    output spq_pkg::cmd_t    cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    cmd.insert   = (status.op_remove == spq_pkg::OP_INSERT) && !status.full;
                    cmd.remove   = (status.op_remove == spq_pkg::OP_REMOVE) && !status.empty;
                    cmd.respond  = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== sv/spq_datapath.sv =====
module spq_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  spq_pkg::cmd_t                       cmd,
    output spq_pkg::status_t                    status,
    input  logic                                s_operation,
    input  logic [spq_pkg::PRIORITY_BITS-1:0]   s_priority_req,
    input  logic [spq_pkg::TAG_BITS-1:0]        s_doc_tag,
    output logic                                m_accepted,
    output logic [spq_pkg::TAG_BITS-1:0]        m_head_tag,
    output logic [spq_pkg::PRIORITY_BITS-1:0]   m_head_priority,
    output logic [spq_pkg::OCC_BITS-1:0]        m_occupancy
);

    localparam int CAP = spq_pkg::CAPACITY;
    localparam int PB  = spq_pkg::PRIORITY_BITS;
    localparam int TB  = spq_pkg::TAG_BITS;
    localparam int CB  = spq_pkg::COUNT_BITS;

    logic [PB-1:0] slot_prio_reg [CAP];
    logic [TB-1:0] slot_tag_reg  [CAP];
    logic [CB-1:0] count_reg;
    logic [CB-1:0] count_next;

    logic          op_reg;
    logic [PB-1:0] req_prio_reg;
    logic [TB-1:0] req_tag_reg;

    logic          accepted_reg;
    logic [TB-1:0] head_tag_reg;
    logic [PB-1:0] head_prio_reg;
    logic [spq_pkg::OCC_BITS-1:0] occ_reg;

    logic [CAP-1:0] lower;
    logic [CAP-1:0] take;
    logic [PB-1:0]  ins_prio [CAP];
    logic [TB-1:0]  ins_tag  [CAP];
    logic [PB-1:0]  rem_prio [CAP];
    logic [TB-1:0]  rem_tag  [CAP];

    assign status.op_remove = op_reg;
    assign status.full      = (count_reg == CB'(CAP));
    assign status.empty     = (count_reg == '0);

    // per-slot compare and shift sources
    for (genvar g = 0; g < CAP; g++) begin : g_slot
        assign lower[g] = (CB'(g) < count_reg) && (slot_prio_reg[g] < req_prio_reg);
        assign take[g]  = lower[g] || (CB'(g) == count_reg);
        if (g == 0) begin : g_first
            assign ins_prio[g] = req_prio_reg;
            assign ins_tag[g]  = req_tag_reg;
        end else begin : g_rest
            assign ins_prio[g] = lower[g-1] ? slot_prio_reg[g-1] : req_prio_reg;
            assign ins_tag[g]  = lower[g-1] ? slot_tag_reg[g-1]  : req_tag_reg;
        end
        if (g == CAP - 1) begin : g_last
            assign rem_prio[g] = slot_prio_reg[g];
            assign rem_tag[g]  = slot_tag_reg[g];
        end else begin : g_inner
            assign rem_prio[g] = slot_prio_reg[g+1];
            assign rem_tag[g]  = slot_tag_reg[g+1];
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.insert) begin
            count_next = count_reg + CB'(1);
        end else if (cmd.remove) begin
            count_next = count_reg - CB'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg       <= s_operation;
            req_prio_reg <= s_priority_req;
            req_tag_reg  <= s_doc_tag;
        end
        if (cmd.insert) begin
            for (int i = 0; i < CAP; i++) begin
                if (take[i]) begin
                    slot_prio_reg[i] <= ins_prio[i];
                    slot_tag_reg[i]  <= ins_tag[i];
                end
            end
        end else if (cmd.remove) begin
            for (int i = 0; i < CAP; i++) begin
                slot_prio_reg[i] <= rem_prio[i];
                slot_tag_reg[i]  <= rem_tag[i];
            end
        end
        if (cmd.respond) begin
            accepted_reg  <= cmd.insert || cmd.remove;
            head_tag_reg  <= cmd.remove ? slot_tag_reg[0]  : '0;
            head_prio_reg <= cmd.remove ? slot_prio_reg[0] : '0;
            occ_reg       <= spq_pkg::OCC_BITS'(count_next);
        end
    end

    assign m_accepted      = accepted_reg;
    assign m_head_tag      = head_tag_reg;
    assign m_head_priority = head_prio_reg;
    assign m_occupancy     = occ_reg;

endmodule

// ===== sv/sorted_priority_queue.sv =====
// channel | valid   | ready   | payload
// request | s_valid | s_ready | s_operation, s_priority_req, s_doc_tag
// result  | m_valid | m_ready | m_accepted, m_head_tag, m_head_priority, m_occupancy
//
// each request is captured in ST_IDLE; then in ST_EXEC, once the result register is free, all slots are
// compared against the new priority and the slot array shifts in parallel
// the result register frees the input side: a new request is taken while a
// result waits, and its update stalls only until that result is taken
// aresetn (synchronous) empties the queue; slot contents are left as they are
module sorted_priority_queue (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_operation,
    input  logic [spq_pkg::PRIORITY_BITS-1:0]   s_priority_req,
    input  logic [spq_pkg::TAG_BITS-1:0]        s_doc_tag,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_accepted,
    output logic [spq_pkg::TAG_BITS-1:0]        m_head_tag,
    output logic [spq_pkg::PRIORITY_BITS-1:0]   m_head_priority,
    output logic [spq_pkg::OCC_BITS-1:0]        m_occupancy
);

    spq_pkg::cmd_t    cmd;
    spq_pkg::status_t status;

    spq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    spq_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_operation     (s_operation),
        .s_priority_req  (s_priority_req),
        .s_doc_tag       (s_doc_tag),
        .m_accepted      (m_accepted),
        .m_head_tag      (m_head_tag),
        .m_head_priority (m_head_priority),
        .m_occupancy     (m_occupancy)
    );

endmodule

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_CYCLES = 10;

    typedef struct {
        logic                              accepted;
        logic [spq_pkg::TAG_BITS-1:0]      head_tag;
        logic [spq_pkg::PRIORITY_BITS-1:0] head_priority;
        logic [spq_pkg::OCC_BITS-1:0]      occupancy;
    } pq_result_t;

    logic                              aclk           = 1'b0;
    logic                              aresetn        = 1'b0;
    logic                              s_valid        = 1'b0;
    logic                              s_ready;
    logic                              s_operation    = spq_pkg::OP_INSERT;
    logic [spq_pkg::PRIORITY_BITS-1:0] s_priority_req = '0;
    logic [spq_pkg::TAG_BITS-1:0]      s_doc_tag      = '0;
    logic                              m_valid;
    logic                              m_ready        = 1'b0;
    logic                              m_accepted;
    logic [spq_pkg::TAG_BITS-1:0]      m_head_tag;
    logic [spq_pkg::PRIORITY_BITS-1:0] m_head_priority;
    logic [spq_pkg::OCC_BITS-1:0]      m_occupancy;

    logic [spq_pkg::PRIORITY_BITS-1:0] shadow_prio [spq_pkg::CAPACITY];
    logic [spq_pkg::TAG_BITS-1:0]      shadow_tag  [spq_pkg::CAPACITY];
    int unsigned                       shadow_count;

    pq_result_t results_due[$];
    int         mismatch_count;
    int         cycle_count;
    int         hold_off_len;
    bit         tx_idle_on;
    bit         rx_idle_on;

    sorted_priority_queue u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_priority_req  (s_priority_req),
        .s_doc_tag       (s_doc_tag),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_accepted      (m_accepted),
        .m_head_tag      (m_head_tag),
        .m_head_priority (m_head_priority),
        .m_occupancy     (m_occupancy)
    );

    always #10 aclk = ~aclk;

    // sorted insert behind equal priorities, remove from the head
    function automatic pq_result_t queue_apply(input logic op,
                                               input logic [spq_pkg::PRIORITY_BITS-1:0] prio,
                                               input logic [spq_pkg::TAG_BITS-1:0] tag);
        pq_result_t  r;
        int unsigned pos;
        r.accepted      = 1'b0;
        r.head_tag      = '0;
        r.head_priority = '0;
        if (op == spq_pkg::OP_INSERT) begin
            if (shadow_count < spq_pkg::CAPACITY) begin
                pos = shadow_count;
                for (int i = 0; i < shadow_count; i++) begin
                    if (shadow_prio[i] < prio) begin
                        pos = i;
                        break;
                    end
                end
                for (int i = shadow_count; i > pos; i--) begin
                    shadow_prio[i] = shadow_prio[i-1];
                    shadow_tag[i]  = shadow_tag[i-1];
                end
                shadow_prio[pos] = prio;
                shadow_tag[pos]  = tag;
                shadow_count++;
                r.accepted = 1'b1;
            end
        end else begin
            if (shadow_count > 0) begin
                r.head_tag      = shadow_tag[0];
                r.head_priority = shadow_prio[0];
                for (int i = 0; i + 1 < shadow_count; i++) begin
                    shadow_prio[i] = shadow_prio[i+1];
                    shadow_tag[i]  = shadow_tag[i+1];
                end
                shadow_count--;
                r.accepted = 1'b1;
            end
        end
        r.occupancy = shadow_count[spq_pkg::OCC_BITS-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side ready, with random stalls and a long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_len > 0) begin
                m_ready <= 1'b0;
                repeat (hold_off_len) @(posedge aclk);
                hold_off_len = 0;
                m_ready <= 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        pq_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (results_due.size() == 0) begin
                $error("result with no request outstanding");
                mismatch_count++;
            end else begin
                want = results_due.pop_front();
                if (m_accepted !== want.accepted) begin
                    $error("m_accepted: expected %0d, got %0d", want.accepted, m_accepted);
                    mismatch_count++;
                end
                if (m_head_tag !== want.head_tag) begin
                    $error("m_head_tag: expected %h, got %h", want.head_tag, m_head_tag);
                    mismatch_count++;
                end
                if (m_head_priority !== want.head_priority) begin
                    $error("m_head_priority: expected %0d, got %0d",
                           want.head_priority, m_head_priority);
                    mismatch_count++;
                end
                if (m_occupancy !== want.occupancy) begin
                    $error("m_occupancy: expected %0d, got %0d", want.occupancy, m_occupancy);
                    mismatch_count++;
                end
            end
        end
    end

    // called just after a rising edge, returns just after the edge that took the request or after a random idle gap
    task automatic send_request(input logic op,
                                input logic [spq_pkg::PRIORITY_BITS-1:0] prio,
                                input logic [spq_pkg::TAG_BITS-1:0] tag);
        s_valid        <= 1'b1;
        s_operation    <= op;
        s_priority_req <= prio;
        s_doc_tag      <= tag;
        do @(posedge aclk); while (!s_ready);
        results_due.push_back(queue_apply(op, prio, tag));
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_due.size() != 0);
    endtask

    task automatic test_remove_when_empty();
        send_request(spq_pkg::OP_REMOVE, '1, '1);
        wait_drained();
    endtask

    task automatic test_fill_and_overflow();
        logic [spq_pkg::PRIORITY_BITS-1:0] prios [16] = '{8'h80, 8'hFF, 8'h00, 8'hFF,
                                                          8'h80, 8'h00, 8'h7F, 8'h01,
                                                          8'hFE, 8'h80, 8'h55, 8'hAA,
                                                          8'hFF, 8'h00, 8'h7F, 8'h80};
        logic [spq_pkg::TAG_BITS-1:0]      tag;
        for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
            case (i)
                0:       tag = '0;
                1:       tag = '1;
                2:       tag = 32'hAAAA_AAAA;
                3:       tag = 32'h5555_5555;
                default: tag = $urandom;
            endcase
            send_request(spq_pkg::OP_INSERT, prios[i % 16], tag);
        end
        // full queue refuses the insert
        send_request(spq_pkg::OP_INSERT, 8'hFF, 32'hDEAD_BEEF);
        wait_drained();
    endtask

    task automatic test_remove_order();
        repeat (6) begin
            send_request(spq_pkg::OP_REMOVE, spq_pkg::PRIORITY_BITS'($urandom), $urandom);
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        tx_idle_on   = 1'b0;
        rx_idle_on   = 1'b0;
        hold_off_len = 300;
        repeat (40) begin
            send_request($urandom_range(0, 2) == 0 ? spq_pkg::OP_REMOVE : spq_pkg::OP_INSERT,
                         spq_pkg::PRIORITY_BITS'($urandom_range(0, 3)), $urandom);
        end
        wait_drained();
    endtask

    task automatic test_random_traffic(input int n_items, input bit with_idling);
        int                                sent;
        int                                insert_pct;
        logic                              op;
        logic [spq_pkg::PRIORITY_BITS-1:0] prio;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(0, 2))
                0:       insert_pct = 80;
                1:       insert_pct = 25;
                default: insert_pct = 50;
            endcase
            tx_idle_on = with_idling && $urandom_range(0, 2) != 0;
            rx_idle_on = with_idling && $urandom_range(0, 2) != 0;
            repeat ($urandom_range(8, 40)) begin
                op = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::OP_INSERT
                                                          : spq_pkg::OP_REMOVE;
                case ($urandom_range(0, 3))
                    0:       prio = spq_pkg::PRIORITY_BITS'($urandom_range(0, 3));
                    1:       prio = $urandom_range(0, 1) ? '1 : '0;
                    default: prio = spq_pkg::PRIORITY_BITS'($urandom);
                endcase
                send_request(op, prio, $urandom);
                sent++;
            end
        end
        wait_drained();
    endtask

    initial begin
        shadow_count   = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        hold_off_len   = 0;
        tx_idle_on     = 1'b0;
        rx_idle_on     = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_remove_when_empty();
        test_fill_and_overflow();
        test_remove_order();
        test_backpressure();
        test_random_traffic(540, 1'b1);
        test_random_traffic(100, 1'b0);

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && results_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sorted_priority_queue.f =====
sv/spq_pkg.sv
sv/spq_ctrl.sv
sv/spq_datapath.sv
sv/sorted_priority_queue.sv
tb/testbench.sv
